[sv/lss_pkg.sv]
// Shared types, constants and kernel table for the Laplacian sharpening stream.
// No dependencies; used by lss_cell and the top level of the block.
`timescale 1ns / 1ps

package lss_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT    = 4096;
   localparam int MIN_DIM       = 5;

   localparam int PIX_W  = 8;
   localparam int BLUR_W = 16;
   localparam int SUM_W  = 17;
   localparam int X_W    = 25;
   localparam int EDGE_W = 20;
   localparam int PROD_W = 33;
   localparam int T_W    = 35;
   localparam int ROW_W  = 13;

   localparam int FW_W   = 11;
   localparam int FH_W   = 13;
   localparam int STR_W  = 12;
   localparam int CSR_DW = 13;
   localparam int CSR_IW = 2;

   localparam logic [CSR_IW-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IW-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IW-1:0] REG_STRENGTH     = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam int FRAME_WIDTH_RST  = 640;
   localparam int FRAME_HEIGHT_RST = 480;
   localparam int STRENGTH_RST     = 256;

   // floor(2^32 / 273): quotient estimate is exact or one low
   localparam logic [23:0] RECIP_273 = 24'd15732480;
   localparam int          DIV_273   = 273;
   localparam int          ROUND_273 = 136;
   localparam int          ROUND_OUT = 32768;

   localparam logic [5:0] GAUSS [5][5] = '{
      '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
      '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
      '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
      '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
      '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}};

   typedef struct packed {
      logic             cmd;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             frame_end;
   } rsp_type;

   // per-step control carried down the pipeline
   typedef struct packed {
      logic [4:0] cmask;   // window column inside the frame
      logic       bzero;   // blur row below the frame
      logic       emit;    // step produces a result
      logic       upok;
      logic       lok;
      logic       rok;
      logic       last;
   } step_info_type;

endpackage

[sv/lss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lss_cell.sv]
// One column cell of the 5x5 blur window: holds a column, weights it, passes it on.
// Depends on lss_pkg (kernel table, widths).
`timescale 1ns / 1ps

module lss_cell #(
   parameter int IDX = 0
) (
   input  logic                              clock,
   input  logic                              shift_en,
   input  logic [4:0][lss_pkg::PIX_W-1:0]    col_in,
   output logic [4:0][lss_pkg::PIX_W-1:0]    col_out,
   output logic [lss_pkg::SUM_W-1:0]         wsum
);

   logic [4:0][lss_pkg::PIX_W-1:0] col_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   always_comb begin
      logic [lss_pkg::SUM_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < 5; k++) begin
         acc = acc + lss_pkg::SUM_W'(lss_pkg::GAUSS[IDX][k]) *
               lss_pkg::SUM_W'(col_ff[k]);
      end
      wsum = acc;
   end

   assign col_out = col_ff;

endmodule

[sv/laplacian_sharpen_stream_unit.sv]
// Top level of the Laplacian sharpening stream: control, window cells, divider,
// Laplacian and gain pipeline. Depends on lss_pkg, lss_ram and lss_cell.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  lss_pkg::req_type  (cmd, pixel_in)
// rsp      out        rsp_valid/rsp_ready  lss_pkg::rsp_type  (pixel_out, frame_end)
// csr      in         csr_valid/csr_ready  csr_index, csr_data (width, height, strength)
//
// One transaction per clock sustained while the output register is not stalled. A
// result leaves after the transaction that causes it has passed the row RAM read and
// step info at the accepting edge, then window cells, blur sum, two divide steps,
// blurred-row RAM, Laplacian, gain multiply and the output register.
// Reset is synchronous; the row RAMs are not cleared (rows are read only after
// being written in the same frame). The whole pipeline stalls only while the
// output register holds a result that is not taken; csr_ready is always high.

module laplacian_sharpen_stream_unit #(
   parameter int MAX_WIDTH = lss_pkg::MAX_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lss_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lss_pkg::rsp_type           rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lss_pkg::CSR_IW-1:0] csr_index,
   input  logic [lss_pkg::CSR_DW-1:0] csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int W_RST = (lss_pkg::FRAME_WIDTH_RST < MAX_WIDTH) ?
                          lss_pkg::FRAME_WIDTH_RST : MAX_WIDTH;
   localparam int PW = lss_pkg::PIX_W;
   localparam int BW = lss_pkg::BLUR_W;
   localparam int RW = lss_pkg::ROW_W;

   // ---------------- configuration registers ----------------
   logic [lss_pkg::FW_W-1:0]  frame_width_ff;
   logic [lss_pkg::FH_W-1:0]  frame_height_ff;
   logic [lss_pkg::STR_W-1:0] strength_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= lss_pkg::FW_W'(lss_pkg::FRAME_WIDTH_RST);
         frame_height_ff <= lss_pkg::FH_W'(lss_pkg::FRAME_HEIGHT_RST);
         strength_ff     <= lss_pkg::STR_W'(lss_pkg::STRENGTH_RST);
      end else if (csr_valid) begin
         case (csr_index)
            lss_pkg::REG_FRAME_WIDTH: begin
               frame_width_ff <= csr_data[lss_pkg::FW_W-1:0];
            end
            lss_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data[lss_pkg::FH_W-1:0];
            end
            lss_pkg::REG_STRENGTH: begin
               strength_ff <= csr_data[lss_pkg::STR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------- pipeline flow ----------------
   logic rsp_vld_ff;
   logic adv;
   assign adv       = !rsp_vld_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- front end: frame counters ----------------
   logic [WW-1:0] lat_w_ff, w_reg, w_cur;
   logic [RW-1:0] lat_h_ff, h_reg, h_cur;
   logic [RW-1:0] arow_ff, arow_in, brow_ff, brow_in;
   logic [AW-1:0] acol_ff, acol_in, bcol_ff, bcol_in;
   logic          first, full, do_step, step, blur_on, awrap, bwrap;
   logic [WW-1:0] acol_nx, bcol_nx;
   logic [AW-1:0] nxt;
   logic [3:0]    rowok;
   logic [PW-1:0] px;
   lss_pkg::step_info_type info;

   always_comb begin
      if (frame_width_ff < lss_pkg::FW_W'(lss_pkg::MIN_DIM)) begin
         w_reg = WW'(lss_pkg::MIN_DIM);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w_reg = WW'(MAX_WIDTH);
      end else begin
         w_reg = WW'(frame_width_ff);
      end
      if (frame_height_ff < lss_pkg::FH_W'(lss_pkg::MIN_DIM)) begin
         h_reg = RW'(lss_pkg::MIN_DIM);
      end else if (32'(frame_height_ff) > lss_pkg::MAX_HEIGHT) begin
         h_reg = RW'(lss_pkg::MAX_HEIGHT);
      end else begin
         h_reg = RW'(frame_height_ff);
      end
   end

   // geometry is taken from the registers on the first pixel of a frame
   assign first = (arow_ff == '0) && (acol_ff == '0);
   assign w_cur = first ? w_reg : lat_w_ff;
   assign h_cur = first ? h_reg : lat_h_ff;
   assign full  = arow_ff >= h_cur;

   // pixels after the frame is complete and flushes before it are dropped
   assign do_step = (req_data.cmd == lss_pkg::CMD_PIXEL) ? !full : (!first && full);
   assign step    = req_valid && adv && do_step;

   assign blur_on = (arow_ff > RW'(2)) || ((arow_ff == RW'(2)) && (acol_ff >= AW'(2)));
   assign acol_nx = WW'(acol_ff) + WW'(1);
   assign awrap   = acol_nx == w_cur;
   assign bcol_nx = WW'(bcol_ff) + WW'(1);
   assign bwrap   = bcol_nx == w_cur;
   // read-ahead column of the blurred row; wraps to 0 to pick up the next row start
   assign nxt     = bwrap ? '0 : AW'(bcol_nx);
   assign px      = (arow_ff < h_cur) ? req_data.pixel_in : '0;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         rowok[k] = (arow_ff >= RW'(4 - k)) &&
                    ((RW+1)'(arow_ff) + (RW+1)'(k) < (RW+1)'(h_cur) + (RW+1)'(4));
      end
      info.cmask[0] = (WW+1)'(bcol_ff) + (WW+1)'(2) < (WW+1)'(w_cur);
      info.cmask[1] = !bwrap;
      info.cmask[2] = 1'b1;
      info.cmask[3] = bcol_ff >= AW'(1);
      info.cmask[4] = bcol_ff >= AW'(2);
      info.bzero    = brow_ff >= h_cur;
      info.emit     = brow_ff != '0;
      info.upok     = brow_ff >= RW'(2);
      info.lok      = bcol_ff != '0;
      info.rok      = !bwrap;
      info.last     = (brow_ff == h_cur) && bwrap;
   end

   always_comb begin
      arow_in = arow_ff;
      acol_in = acol_ff;
      brow_in = brow_ff;
      bcol_in = bcol_ff;
      if (step) begin
         if (blur_on && info.last) begin
            arow_in = '0;
            acol_in = '0;
            brow_in = '0;
            bcol_in = '0;
         end else begin
            if (awrap) begin
               acol_in = '0;
               arow_in = arow_ff + RW'(1);
            end else begin
               acol_in = AW'(acol_nx);
            end
            if (blur_on) begin
               if (bwrap) begin
                  bcol_in = '0;
                  brow_in = brow_ff + RW'(1);
               end else begin
                  bcol_in = AW'(bcol_nx);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arow_ff  <= '0;
         acol_ff  <= '0;
         brow_ff  <= '0;
         bcol_ff  <= '0;
         lat_w_ff <= WW'(W_RST);
         lat_h_ff <= RW'(lss_pkg::FRAME_HEIGHT_RST);
      end else begin
         arow_ff <= arow_in;
         acol_ff <= acol_in;
         brow_ff <= brow_in;
         bcol_ff <= bcol_in;
         if (step && first) begin
            lat_w_ff <= w_reg;
            lat_h_ff <= h_reg;
         end
      end
   end

   // ---------------- input row store: four row slots ----------------
   logic [3:0][PW-1:0] row_rd;

   for (genvar i = 0; i < 4; i++) begin : g_in_row
      lss_ram #(.WIDTH(PW), .DEPTH(MAX_WIDTH)) u_row (
         .clock   (clock),
         .wr_en   (step && (arow_ff < h_cur) && (arow_ff[1:0] == 2'(i))),
         .wr_addr (acol_ff),
         .wr_data (req_data.pixel_in),
         .rd_en   (step),
         .rd_addr (acol_ff),
         .rd_data (row_rd[i])
      );
   end

   // stage A: row reads land, step info registered
   logic                   a_vld_ff, a_blur_ff;
   logic [PW-1:0]          a_px_ff;
   logic [3:0]             a_rowok_ff;
   logic [1:0]             a_slot_ff;
   lss_pkg::step_info_type a_info_ff;
   logic [AW-1:0]          a_bcol_ff, a_nxt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_blur_ff  <= blur_on;
         a_px_ff    <= px;
         a_rowok_ff <= rowok;
         a_slot_ff  <= arow_ff[1:0];
         a_info_ff  <= info;
         a_bcol_ff  <= bcol_ff;
         a_nxt_ff   <= nxt;
      end
   end

   // ---------------- window: chain of five column cells ----------------
   logic [4:0][PW-1:0]          new_col;
   logic [4:0][4:0][PW-1:0]     cell_col;
   logic [4:0][lss_pkg::SUM_W-1:0] cell_sum;

   // oldest row on index 0, incoming pixel on index 4
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         new_col[k] = a_rowok_ff[k] ? row_rd[2'(a_slot_ff + 2'(k))] : '0;
      end
      new_col[4] = a_px_ff;
   end

   for (genvar d = 0; d < 5; d++) begin : g_cell
      lss_cell #(.IDX(d)) u_cell (
         .clock    (clock),
         .shift_en (adv && a_vld_ff),
         .col_in   ((d == 0) ? new_col : cell_col[(d == 0) ? 0 : d - 1]),
         .col_out  (cell_col[d]),
         .wsum     (cell_sum[d])
      );
   end

   // stage B: window holds this step's columns
   logic                   b_vld_ff;
   lss_pkg::step_info_type b_info_ff;
   logic [AW-1:0]          b_bcol_ff, b_nxt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff && a_blur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_info_ff <= a_info_ff;
         b_bcol_ff <= a_bcol_ff;
         b_nxt_ff  <= a_nxt_ff;
      end
   end

   // stage C: blur sum over the columns inside the frame
   logic [lss_pkg::SUM_W-1:0] sum_in;
   logic                   c_vld_ff;
   logic [lss_pkg::SUM_W-1:0] c_sum_ff;
   logic [PW-1:0]          c_orig_ff;
   lss_pkg::step_info_type c_info_ff;
   logic [AW-1:0]          c_bcol_ff, c_nxt_ff;

   always_comb begin
      sum_in = '0;
      for (int d = 0; d < 5; d++) begin
         if (b_info_ff.cmask[d]) begin
            sum_in = sum_in + cell_sum[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_sum_ff  <= sum_in;
         c_orig_ff <= cell_col[2][1];   // original pixel one row above the blur center
         c_info_ff <= b_info_ff;
         c_bcol_ff <= b_bcol_ff;
         c_nxt_ff  <= b_nxt_ff;
      end
   end

   // stage D: quotient estimate of (sum*256 + 136) / 273
   logic [lss_pkg::X_W-1:0] x_in;
   logic [48:0]            qprod;
   logic                   d_vld_ff;
   logic [lss_pkg::X_W-1:0] d_x_ff;
   logic [BW-1:0]          d_q_ff;
   logic [PW-1:0]          d_orig_ff;
   lss_pkg::step_info_type d_info_ff;
   logic [AW-1:0]          d_bcol_ff, d_nxt_ff;

   assign x_in  = {c_sum_ff, 8'b0} + lss_pkg::X_W'(lss_pkg::ROUND_273);
   assign qprod = 49'(x_in) * 49'(lss_pkg::RECIP_273);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (adv) begin
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_x_ff    <= x_in;
         d_q_ff    <= qprod[47:32];
         d_orig_ff <= c_orig_ff;
         d_info_ff <= c_info_ff;
         d_bcol_ff <= c_bcol_ff;
         d_nxt_ff  <= c_nxt_ff;
      end
   end

   // stage E: correct the estimate by one, or zero it for a blur row below the frame
   logic [lss_pkg::X_W-1:0] rem;
   logic [BW-1:0]          b_in;
   logic                   e_vld_ff;
   logic [BW-1:0]          e_b_ff;
   logic [PW-1:0]          e_orig_ff;
   lss_pkg::step_info_type e_info_ff;
   logic [AW-1:0]          e_bcol_ff, e_nxt_ff;

   always_comb begin
      rem = d_x_ff - lss_pkg::X_W'(lss_pkg::X_W'(d_q_ff) * lss_pkg::X_W'(lss_pkg::DIV_273));
      if (d_info_ff.bzero) begin
         b_in = '0;
      end else if (rem >= lss_pkg::X_W'(lss_pkg::DIV_273)) begin
         b_in = d_q_ff + BW'(1);
      end else begin
         b_in = d_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_b_ff    <= b_in;
         e_orig_ff <= d_orig_ff;
         e_info_ff <= d_info_ff;
         e_bcol_ff <= d_bcol_ff;
         e_nxt_ff  <= d_nxt_ff;
      end
   end

   // ---------------- blurred rows: two chained row delay lines ----------------
   // line 1 is read one column ahead (right neighbor); its output, one step old,
   // is the center and feeds line 2, whose output is the row above.
   logic          e_go;
   logic [BW-1:0] rd1, rd2;

   assign e_go = adv && e_vld_ff;

   lss_ram #(.WIDTH(BW), .DEPTH(MAX_WIDTH)) u_blur_near (
      .clock   (clock),
      .wr_en   (e_go),
      .wr_addr (e_bcol_ff),
      .wr_data (e_b_ff),
      .rd_en   (e_go),
      .rd_addr (e_nxt_ff),
      .rd_data (rd1)
   );

   lss_ram #(.WIDTH(BW), .DEPTH(MAX_WIDTH)) u_blur_far (
      .clock   (clock),
      .wr_en   (e_go),
      .wr_addr (e_bcol_ff),
      .wr_data (rd1),
      .rd_en   (e_go),
      .rd_addr (e_bcol_ff),
      .rd_data (rd2)
   );

   // stage F
   logic                   f_vld_ff;
   logic [BW-1:0]          f_b_ff, f_c_ff, f_l_ff;
   logic [PW-1:0]          f_orig_ff;
   lss_pkg::step_info_type f_info_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= e_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_b_ff    <= e_b_ff;
         f_orig_ff <= e_orig_ff;
         f_info_ff <= e_info_ff;
      end
      if (e_go) begin
         f_c_ff <= rd1;
         f_l_ff <= f_c_ff;
      end
   end

   // stage G: edge = 4*center - up - left - right - down, neighbors outside the frame left out
   logic [lss_pkg::EDGE_W-1:0] edge_in;
   logic                       g_vld_ff;
   logic signed [lss_pkg::EDGE_W-1:0] g_edge_ff;
   logic [PW-1:0]              g_orig_ff;
   logic                       g_last_ff;

   always_comb begin
      edge_in = {2'b00, f_c_ff, 2'b00};
      if (f_info_ff.upok) begin
         edge_in = edge_in - {4'b0, rd2};
      end
      if (f_info_ff.lok) begin
         edge_in = edge_in - {4'b0, f_l_ff};
      end
      if (f_info_ff.rok) begin
         edge_in = edge_in - {4'b0, rd1};
      end
      edge_in = edge_in - {4'b0, f_b_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= f_vld_ff && f_info_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_edge_ff <= $signed(edge_in);
         g_orig_ff <= f_orig_ff;
         g_last_ff <= f_info_ff.last;
      end
   end

   // stage H: gain multiply (strength is read live)
   logic                              h_vld_ff;
   logic signed [lss_pkg::PROD_W-1:0] h_prod_ff;
   logic [PW-1:0]                     h_orig_ff;
   logic                              h_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_prod_ff <= $signed({1'b0, strength_ff}) * g_edge_ff;
         h_orig_ff <= g_orig_ff;
         h_last_ff <= g_last_ff;
      end
   end

   // output: round half up in Q.16, saturate to 0..255
   logic signed [lss_pkg::T_W-1:0] t_sum;
   logic [PW-1:0]                  pix_in;
   lss_pkg::rsp_type               rsp_ff;

   always_comb begin
      t_sum = $signed({11'b0, h_orig_ff, 16'b0}) + lss_pkg::T_W'(h_prod_ff) +
              lss_pkg::T_W'(lss_pkg::ROUND_OUT);
      if (t_sum < 0) begin
         pix_in = '0;
      end else if (t_sum[lss_pkg::T_W-1:24] != '0) begin
         pix_in = '1;
      end else begin
         pix_in = t_sum[23:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff.pixel_out <= pix_in;
         rsp_ff.frame_end <= h_last_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
